// File: hdl/i2c_master_byte_engine_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// Check that a holds only together with b on the same edge.
`define I2CMBE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: same-cycle check failed");

// Check that b holds on the edge after a.
`define I2CMBE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: next-cycle check failed");

`endif

// File: hdl/i2cmbe_pkg.sv
package i2cmbe_pkg;

	// Bus widths of the stream ports and the delay setting
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int QP_W        = 16;

	// Reset value of the bus delay step
	localparam logic [QP_W-1:0] QP_RESET = 16'd50;

	// Default command queue depth (two or more)
	localparam int Q_DEPTH_DEF = 4;

	// Raw opcodes on the input stream
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// Bit positions of the result fields in the output tdata
	localparam int OB_SCL  = 0;
	localparam int OB_SDA  = 1;
	localparam int OB_BUSY = 2;
	localparam int OB_DONE = 3;
	localparam int OB_ACK  = 4;
	localparam int OB_RX   = 5;
	localparam int OB_REJ  = 13;

	// Decoded command kind
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_kind_t;

	// One queued item
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  tx_byte;
		logic        rd_ack;
		logic        sda_in;
	} cmd_item_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hdl/i2cmbe_front.sv
module i2cmbe_front
	import i2cmbe_pkg::*;
(
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  q_stat_t               q_stat,
	output logic                  push,
	output cmd_item_t             push_item
);

	logic [2:0] opcode;

	assign opcode = s_tdata[2:0];

	// Take an item whenever the queue has room
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	// Classify the opcode; unknown codes act as no command
	always_comb begin
		case (opcode)
			OP_START: push_item.kind = CMD_START;
			OP_STOP:  push_item.kind = CMD_STOP;
			OP_WRITE: push_item.kind = CMD_WRITE;
			OP_READ:  push_item.kind = CMD_READ;
			default:  push_item.kind = CMD_NONE;
		endcase
		push_item.tx_byte = s_tdata[10:3];
		push_item.rd_ack  = s_tdata[11];
		push_item.sda_in  = s_tdata[12];
	end

endmodule

// File: hdl/i2cmbe_queue.sv
module i2cmbe_queue
	import i2cmbe_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_item_t push_item,
	input  logic      pop,
	output cmd_item_t head,
	output q_stat_t   stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cmd_item_t        mem_q [DEPTH];
	cmd_item_t        head_q;
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW-1:0]    rd_nxt;
	logic [CW-1:0]    cnt_q;

	// Step the read pointer past a popped item
	assign rd_nxt = !pop ? rd_ptr_q : ((rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1));

	// Store pushed items; fetch the entry under the next read pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
		if (push && (wr_ptr_q == rd_nxt)) begin
			head_q <= push_item;
		end else begin
			head_q <= mem_q[rd_nxt];
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			rd_ptr_q <= rd_nxt;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = head_q;
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// File: hdl/i2cmbe_back.sv
module i2cmbe_back
	import i2cmbe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [QP_W-1:0]        cfg_wdata,
	input  q_stat_t                q_stat,
	input  cmd_item_t              head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	typedef enum logic [18:0] {
		PH_IDLE = 19'h00001,
		PH_ST_A = 19'h00002,
		PH_ST_B = 19'h00004,
		PH_ST_C = 19'h00008,
		PH_SP_A = 19'h00010,
		PH_SP_B = 19'h00020,
		PH_SP_C = 19'h00040,
		PH_WR_D = 19'h00080,
		PH_WR_H = 19'h00100,
		PH_WR_L = 19'h00200,
		PH_WA_R = 19'h00400,
		PH_WA_H = 19'h00800,
		PH_WA_L = 19'h01000,
		PH_RD_W = 19'h02000,
		PH_RD_H = 19'h04000,
		PH_RD_L = 19'h08000,
		PH_RK_D = 19'h10000,
		PH_RK_H = 19'h20000,
		PH_RK_L = 19'h40000
	} phase_t;

	phase_t            phase_q, n_phase;
	logic [2:0]        bit_idx_q, n_bit_idx;
	logic [7:0]        shift_q, n_shift;
	logic [QP_W-1:0]   dc_q, n_dc;
	logic              scl_q, n_scl;
	logic              sda_q, n_sda;
	logic              ack_seen_q, n_ack_seen;
	logic              ack_tx_q, n_ack_tx;
	logic [7:0]        rx_hold_q, n_rx_hold;
	logic [QP_W-1:0]   qp_q;
	logic [QP_W-1:0]   load;
	logic              is_cmd;
	logic              done;
	logic              rej;
	logic              fire;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] res_data;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// Execute the head item when the output register is free or draining
	assign fire = !q_stat.empty && (!out_valid_q || m_tready);
	assign pop  = fire;

	assign is_cmd = (head.kind != CMD_NONE);
	assign load   = (qp_q == '0) ? '0 : qp_q - QP_W'(1);

	// Step the bus sequencer by one item
	always_comb begin
		n_phase    = phase_q;
		n_bit_idx  = bit_idx_q;
		n_shift    = shift_q;
		n_dc       = dc_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_ack_seen = ack_seen_q;
		n_ack_tx   = ack_tx_q;
		n_rx_hold  = rx_hold_q;
		done       = 1'b0;
		rej        = 1'b0;
		if (phase_q != PH_IDLE) begin
			rej = is_cmd;
			if (dc_q != '0) begin
				n_dc = dc_q - QP_W'(1);
			end else begin
				n_dc = load;
				case (phase_q)
					PH_ST_A: begin n_sda = 1'b0; n_phase = PH_ST_B; end
					PH_ST_B: begin n_scl = 1'b0; n_phase = PH_ST_C; end
					PH_SP_A: begin n_scl = 1'b1; n_phase = PH_SP_B; end
					PH_SP_B: begin n_sda = 1'b1; n_phase = PH_SP_C; end
					PH_WR_D: begin n_scl = 1'b1; n_phase = PH_WR_H; end
					PH_WR_H: begin n_scl = 1'b0; n_phase = PH_WR_L; end
					PH_WR_L: begin
						if (bit_idx_q != '0) begin
							n_bit_idx = bit_idx_q - 3'd1;
							n_sda     = shift_q[n_bit_idx];
							n_phase   = PH_WR_D;
						end else begin
							n_sda   = 1'b1;
							n_phase = PH_WA_R;
						end
					end
					PH_WA_R: begin n_scl = 1'b1; n_phase = PH_WA_H; end
					PH_WA_H: begin
						n_ack_seen = head.sda_in;
						n_scl      = 1'b0;
						n_phase    = PH_WA_L;
					end
					PH_RD_W: begin n_scl = 1'b1; n_phase = PH_RD_H; end
					PH_RD_H: begin
						n_shift[bit_idx_q] = shift_q[bit_idx_q] | head.sda_in;
						n_scl   = 1'b0;
						n_phase = PH_RD_L;
					end
					PH_RD_L: begin
						if (bit_idx_q != '0) begin
							n_bit_idx = bit_idx_q - 3'd1;
							n_phase   = PH_RD_W;
						end else begin
							n_sda   = !ack_tx_q;
							n_phase = PH_RK_D;
						end
					end
					PH_RK_D: begin n_scl = 1'b1; n_phase = PH_RK_H; end
					PH_RK_H: begin n_scl = 1'b0; n_phase = PH_RK_L; end
					PH_RK_L: begin
						n_sda     = 1'b1;
						n_rx_hold = shift_q;
						n_phase   = PH_IDLE;
						done      = 1'b1;
					end
					default: begin
						// end of start, stop and write sequences
						n_phase = PH_IDLE;
						done    = 1'b1;
					end
				endcase
				// counter stays at zero on the finishing step
				if (done) begin
					n_dc = dc_q;
				end
			end
		end else if (is_cmd) begin
			n_dc = load;
			case (head.kind)
				CMD_START: begin
					n_sda   = 1'b1;
					n_scl   = 1'b1;
					n_phase = PH_ST_A;
				end
				CMD_STOP: begin
					n_sda   = 1'b0;
					n_scl   = 1'b0;
					n_phase = PH_SP_A;
				end
				CMD_WRITE: begin
					n_shift   = head.tx_byte;
					n_bit_idx = 3'd7;
					n_sda     = head.tx_byte[7];
					n_phase   = PH_WR_D;
				end
				CMD_READ: begin
					n_shift   = '0;
					n_bit_idx = 3'd7;
					n_ack_tx  = head.rd_ack;
					n_sda     = 1'b1;
					n_phase   = PH_RD_W;
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
		end
	end

	// Hold sequencer state and the delay setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_idx_q  <= '0;
			shift_q    <= '0;
			dc_q       <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_seen_q <= 1'b0;
			ack_tx_q   <= 1'b0;
			rx_hold_q  <= '0;
			qp_q       <= QP_RESET;
		end else begin
			if (cfg_we) begin
				qp_q <= cfg_wdata;
			end
			if (fire) begin
				phase_q    <= n_phase;
				bit_idx_q  <= n_bit_idx;
				shift_q    <= n_shift;
				dc_q       <= n_dc;
				scl_q      <= n_scl;
				sda_q      <= n_sda;
				ack_seen_q <= n_ack_seen;
				ack_tx_q   <= n_ack_tx;
				rx_hold_q  <= n_rx_hold;
			end
		end
	end

	// Track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && !m_tready);
		end
	end

	// Pack the result item
	always_comb begin
		res_data               = '0;
		res_data[OB_SCL]       = n_scl;
		res_data[OB_SDA]       = n_sda;
		res_data[OB_BUSY]      = (n_phase != PH_IDLE);
		res_data[OB_DONE]      = done;
		res_data[OB_ACK]       = n_ack_seen;
		res_data[OB_RX +: 8]   = n_rx_hold;
		res_data[OB_REJ]       = rej;
	end

	// Load the result item
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: hdl/i2c_master_byte_engine_unit.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: opcode, tx_byte, rd_ack, sda_in
// m_*       out  m_tvalid/m_tready   m_tdata: scl_out, sda_out, busy_res, done_res,
//                                             ack_bit, rx_byte, rejected
// cfg_*     in   cfg_we              cfg_wdata: quarter_period
//
// One item in, one result out, one item per clock sustained while m_tready stays
// high; each result is registered through the command queue and the output register.
// The sequencer takes one queued item per cycle; the output register sets
// the pace. A stalled m_tready fills the QUEUE_DEPTH-entry command queue,
// after which s_tready drops.
// Reset: both lines released, sequencer idle, quarter_period 50.
module i2c_master_byte_engine_unit
	import i2cmbe_pkg::*;
#(
	parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] opcode, [10:3] tx_byte, [11] rd_ack, [12] sda_in, [15:13] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_bit,
	// [12:5] rx_byte, [13] rejected, [15:14] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [QP_W-1:0]        cfg_wdata
);

	q_stat_t   q_stat;
	logic      push;
	logic      pop;
	cmd_item_t push_item;
	cmd_item_t head;

	i2cmbe_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	i2cmbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	i2cmbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: hdl/i2cmbe_checker.sv
`include "i2c_master_byte_engine_unit_macros.svh"

module i2cmbe_checker
	import i2cmbe_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result holds
	`I2CMBE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A finishing result never reports busy
	`I2CMBE_ASSERT_IMPLY(a_done_idle, clk, arst_n, m_tvalid && m_tdata[OB_DONE], !m_tdata[OB_BUSY])

	// A rejected command only occurs during a sequence or on its last step
	`I2CMBE_ASSERT_IMPLY(a_rej_busy, clk, arst_n, m_tvalid && m_tdata[OB_REJ], m_tdata[OB_BUSY] || m_tdata[OB_DONE])

	// With no result pending the input side is open
	`I2CMBE_ASSERT_IMPLY(a_drain_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/i2c_master_byte_engine_unit_test.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_test;
	import i2cmbe_pkg::*;

	localparam int         HOLD_CYCLES  = 400;
	localparam int         CYCLE_LIMIT  = 500000;
	localparam int         RANDOM_ITEMS = 450;
	localparam int         SDA_RANDOM   = -1;
	// opcodes outside the command set, taken as no command
	localparam logic [2:0] OP_RSVD_LO  = 3'd5;
	localparam logic [2:0] OP_RSVD_HI  = 3'd7;

	// sequencer position, named after the pin change that comes next
	typedef enum logic [4:0] {
		P_IDLE,
		P_START_SDA, P_START_SCL, P_START_END,
		P_STOP_SCL, P_STOP_SDA, P_STOP_END,
		P_WR_DATA, P_WR_HIGH, P_WR_LOW,
		P_WACK_REL, P_WACK_HIGH, P_WACK_END,
		P_RD_WAIT, P_RD_HIGH, P_RD_LOW,
		P_RACK_DRIVE, P_RACK_HIGH, P_RACK_END
	} seq_phase_t;

	typedef struct packed {
		logic       rej;
		logic [7:0] rx;
		logic       ack;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} bus_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [2:0] opcode, [10:3] tx_byte, [11] rd_ack, [12] sda_in, [15:13] zero
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_bit,
	// [12:5] rx_byte, [13] rejected, [15:14] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [QP_W-1:0]        cfg_wdata = '0;

	// bus engine state as predicted from the accepted items
	logic [15:0] q_period  = QP_RESET;
	seq_phase_t  eng_phase = P_IDLE;
	logic [3:0]  bit_idx   = '0;
	logic [7:0]  shreg     = '0;
	logic [15:0] dly       = '0;
	logic        scl_lv    = 1'b1;
	logic        sda_lv    = 1'b1;
	logic        ack_seen  = 1'b0;
	logic        ack_drive = 1'b0;
	logic [7:0]  rx_last   = '0;

	bus_result_t bus_expect_q[$];
	int          mismatch_count = 0;
	int          item_count = 0;
	int          cycle_count = 0;
	int          gap_pct = 0;
	int          stray_pct = 0;
	bit          quiet = 1'b0;
	int          hold_req = 0;
	int          hold_seen = 0;

	i2c_master_byte_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] step_reload();
		return (q_period == 16'd0) ? 16'd0 : q_period - 16'd1;
	endfunction

	// true when the next item lands on the done cycle
	function automatic bit ends_next();
		return (eng_phase inside {P_START_END, P_STOP_END, P_WACK_END, P_RACK_END})
			&& (dly == 16'd0);
	endfunction

	// apply the pin change due after the current delay; return 1 on the done cycle
	function automatic logic seq_advance(input logic sda);
		logic fin;
		fin = 1'b0;
		case (eng_phase)
			P_START_SDA: begin sda_lv = 1'b0; eng_phase = P_START_SCL; end
			P_START_SCL: begin scl_lv = 1'b0; eng_phase = P_START_END; end
			P_STOP_SCL: begin scl_lv = 1'b1; eng_phase = P_STOP_SDA; end
			P_STOP_SDA: begin sda_lv = 1'b1; eng_phase = P_STOP_END; end
			P_WR_DATA: begin scl_lv = 1'b1; eng_phase = P_WR_HIGH; end
			P_WR_HIGH: begin scl_lv = 1'b0; eng_phase = P_WR_LOW; end
			P_WR_LOW: begin
				if (bit_idx != 4'd0) begin
					bit_idx = bit_idx - 4'd1;
					sda_lv = shreg[bit_idx[2:0]];
					eng_phase = P_WR_DATA;
				end else begin
					sda_lv = 1'b1;
					eng_phase = P_WACK_REL;
				end
			end
			P_WACK_REL: begin scl_lv = 1'b1; eng_phase = P_WACK_HIGH; end
			P_WACK_HIGH: begin
				ack_seen = sda;
				scl_lv = 1'b0;
				eng_phase = P_WACK_END;
			end
			P_RD_WAIT: begin scl_lv = 1'b1; eng_phase = P_RD_HIGH; end
			P_RD_HIGH: begin
				shreg[bit_idx[2:0]] = shreg[bit_idx[2:0]] | sda;
				scl_lv = 1'b0;
				eng_phase = P_RD_LOW;
			end
			P_RD_LOW: begin
				if (bit_idx != 4'd0) begin
					bit_idx = bit_idx - 4'd1;
					eng_phase = P_RD_WAIT;
				end else begin
					sda_lv = ~ack_drive;
					eng_phase = P_RACK_DRIVE;
				end
			end
			P_RACK_DRIVE: begin scl_lv = 1'b1; eng_phase = P_RACK_HIGH; end
			P_RACK_HIGH: begin scl_lv = 1'b0; eng_phase = P_RACK_END; end
			P_RACK_END: begin
				sda_lv = 1'b1;
				rx_last = shreg;
				eng_phase = P_IDLE;
				fin = 1'b1;
			end
			default: begin
				// final delay of start, stop and write
				eng_phase = P_IDLE;
				fin = 1'b1;
			end
		endcase
		return fin;
	endfunction

	// advance the engine by one item and return the line and status it shows
	function automatic bus_result_t bus_step(input logic [2:0] op, input logic [7:0] tx,
			input logic sack, input logic sda);
		bus_result_t r;
		logic is_cmd;
		r = '0;
		is_cmd = (op >= OP_START) && (op <= OP_READ);
		if (eng_phase != P_IDLE) begin
			r.rej = is_cmd;
			if (dly != 16'd0)
				dly = dly - 16'd1;
			else if (seq_advance(sda))
				r.done = 1'b1;
			else
				dly = step_reload();
		end else if (is_cmd) begin
			dly = step_reload();
			case (op)
				OP_START: begin
					sda_lv = 1'b1;
					scl_lv = 1'b1;
					eng_phase = P_START_SDA;
				end
				OP_STOP: begin
					sda_lv = 1'b0;
					scl_lv = 1'b0;
					eng_phase = P_STOP_SCL;
				end
				OP_WRITE: begin
					shreg = tx;
					bit_idx = 4'd7;
					sda_lv = tx[7];
					eng_phase = P_WR_DATA;
				end
				default: begin
					shreg = 8'h00;
					bit_idx = 4'd7;
					ack_drive = sack;
					sda_lv = 1'b1;
					eng_phase = P_RD_WAIT;
				end
			endcase
		end
		r.scl = scl_lv;
		r.sda = sda_lv;
		r.busy = (eng_phase != P_IDLE);
		r.ack = ack_seen;
		r.rx = rx_last;
		return r;
	endfunction

	// offer one item, wait for it to be taken, then predict its result
	task automatic send_item(input logic [2:0] op, input logic [7:0] tx, input logic sack,
			input logic sda);
		int gap;
		if (!quiet && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, sda, sack, tx, op};
		do @(posedge clk); while (!s_tready);
		bus_expect_q.push_back(bus_step(op, tx, sack, sda));
		item_count++;
	endtask

	// issue one command and feed bus samples until the engine is idle again
	task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic sack,
			input int sda_fix, input bit hit_done);
		logic [2:0] fop;
		logic       s;
		send_item(op, tx, sack, (sda_fix == SDA_RANDOM) ? 1'($urandom_range(1)) : sda_fix[0]);
		while (eng_phase != P_IDLE) begin
			s = (sda_fix == SDA_RANDOM) ? 1'($urandom_range(1)) : sda_fix[0];
			if ((hit_done || stray_pct != 0 && $urandom_range(3) == 0) && ends_next())
				fop = 3'($urandom_range(OP_START, OP_READ));
			else if ($urandom_range(99) < stray_pct)
				fop = 3'($urandom_range(OP_START, OP_READ));
			else if ($urandom_range(19) == 0)
				fop = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
			else
				fop = OP_NONE;
			send_item(fop, 8'($urandom), 1'($urandom_range(1)), s);
		end
	endtask

	// wait until every offered item has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (bus_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_period(input logic [15:0] qp);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= qp;
		@(posedge clk);
		q_period = qp;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// start, address byte, a few data bytes in one direction, stop
	task automatic bus_transaction();
		int  n;
		bit  rd;
		run_command(OP_START, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 1'b0);
		run_command(OP_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 1'b0);
		n = $urandom_range(1, 3);
		rd = $urandom_range(1);
		for (int i = 0; i < n; i++) begin
			if (rd)
				run_command(OP_READ, 8'($urandom), (i != n - 1), SDA_RANDOM, 1'b0);
			else
				run_command(OP_WRITE, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 1'b0);
		end
		run_command(OP_STOP, 8'($urandom), 1'($urandom_range(1)), SDA_RANDOM, 1'b0);
	endtask

	function automatic logic [15:0] pick_period();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'($urandom_range(4, 8));
		return 16'($urandom_range(1, 3));
	endfunction

	// reset delay step on a start sequence
	task automatic test_reset_period();
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
	endtask

	// delay step of one: byte and line extremes, ACK and NACK both ways, ignored codes
	task automatic test_commands();
		set_period(16'd1);
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_command(OP_WRITE, 8'h00, 1'b0, 1, 1'b0);
		run_command(OP_WRITE, 8'hFF, 1'b1, 0, 1'b0);
		run_command(OP_READ, 8'h00, 1'b0, 1, 1'b0);
		run_command(OP_READ, 8'hFF, 1'b1, 0, 1'b0);
		run_command(OP_READ, 8'h5A, 1'b1, SDA_RANDOM, 1'b0);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++)
			send_item(3'(c), 8'hFF, 1'b1, 1'b1);
		// command on the done cycle is refused, the next one right after is taken
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		// commands while busy, of random kinds
		stray_pct = 30;
		run_command(OP_WRITE, 8'h81, 1'b0, SDA_RANDOM, 1'b0);
		stray_pct = 0;
	endtask

	task automatic test_zero_period();
		set_period(16'd0);
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_command(OP_WRITE, 8'($urandom), 1'b0, SDA_RANDOM, 1'b0);
		run_command(OP_READ, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
	endtask

	// hold the result side off while a transaction keeps the input busy
	task automatic test_backpressure();
		set_period(16'd2);
		hold_req++;
		bus_transaction();
	endtask

	task automatic test_random();
		int target;
		int n;
		target = item_count + RANDOM_ITEMS;
		while (item_count < target) begin
			set_period(pick_period());
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 4;
				default: gap_pct = 12;
			endcase
			stray_pct = $urandom_range(2);
			n = $urandom_range(1, 2);
			repeat (n) begin
				if ($urandom_range(4) != 0)
					bus_transaction();
				else
					run_command(3'($urandom_range(OP_START, OP_READ)), 8'($urandom),
						1'($urandom_range(1)), SDA_RANDOM, 1'b0);
			end
		end
		stray_pct = 0;
	endtask

	// no idling from here on; a longer delay step last
	task automatic test_long_period();
		quiet = 1'b1;
		set_period(16'd1);
		bus_transaction();
		set_period(16'd24);
		run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_seen = hold_req;
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(99) < gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result taken with the oldest prediction
	always @(posedge clk) begin : result_check
		bus_result_t exp_r;
		bus_result_t got_r;
		if (arst_n && m_tvalid && m_tready) begin
			got_r.scl = m_tdata[OB_SCL];
			got_r.sda = m_tdata[OB_SDA];
			got_r.busy = m_tdata[OB_BUSY];
			got_r.done = m_tdata[OB_DONE];
			got_r.ack = m_tdata[OB_ACK];
			got_r.rx = m_tdata[OB_RX +: 8];
			got_r.rej = m_tdata[OB_REJ];
			if (bus_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with no item pending: %h", $realtime, m_tdata);
			end else begin
				exp_r = bus_expect_q.pop_front();
				if (got_r !== exp_r) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: exp scl=%b sda=%b busy=%b done=%b ack=%b rx=%h rej=%b",
							" / got scl=%b sda=%b busy=%b done=%b ack=%b rx=%h rej=%b"},
							$realtime, exp_r.scl, exp_r.sda, exp_r.busy, exp_r.done,
							exp_r.ack, exp_r.rx, exp_r.rej, got_r.scl, got_r.sda,
							got_r.busy, got_r.done, got_r.ack, got_r.rx, got_r.rej);
				end
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("i2c_master_byte_engine_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_period();
		test_commands();
		test_zero_period();
		test_backpressure();
		test_random();
		test_long_period();
		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && bus_expect_q.size() == 0)
			$display("i2c_master_byte_engine_unit: match");
		else
			$display("i2c_master_byte_engine_unit: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_front.sv
hdl/i2cmbe_queue.sv
hdl/i2cmbe_back.sv
hdl/i2c_master_byte_engine_unit.sv
hdl/i2cmbe_checker.sv
sim/i2c_master_byte_engine_unit_test.sv
